// ===== design/scpi_pkg.sv =====
// shared types and codes for the sorted candidate pool
package scpi_pkg;

	localparam int CFG_W = 7;
	localparam int IDX_W = 6;
	localparam int POS_W = 6;
	localparam logic [CFG_W-1:0] POOL_SIZE_RESET = 7'd64;

	// operation codes
	localparam logic [1:0] FN_CLEAR    = 2'd0;
	localparam logic [1:0] FN_INSERT   = 2'd1;
	localparam logic [1:0] FN_READ     = 2'd2;
	localparam logic [1:0] FN_FLAG_CLR = 2'd3;

	// result status codes
	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_BEYOND    = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_DONE      = 2'd3;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] distance;
		logic        flag;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{id: 32'hFFFF_FFFF, distance: 32'hFFFF_FFFF,
		flag: 1'b0};

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] position;
		logic [31:0]      entry_id;
		logic [31:0]      entry_distance;
		logic             entry_flag;
	} res_t;

endpackage

// ===== design/scpi_req_if.sv =====
// request channel of the candidate pool
interface scpi_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] new_id;
	logic [31:0] new_distance;
	logic [5:0]  entry_index;

	modport source (output valid, func, new_id, new_distance, entry_index, input ready);
	modport sink   (input valid, func, new_id, new_distance, entry_index, output ready);
endinterface

// ===== design/scpi_rsp_if.sv =====
// response channel of the candidate pool
interface scpi_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  position;
	logic [31:0] entry_id;
	logic [31:0] entry_distance;
	logic        entry_flag;

	modport source (output valid, status, position, entry_id, entry_distance, entry_flag,
		input ready);
	modport sink   (input valid, status, position, entry_id, entry_distance, entry_flag,
		output ready);
endinterface

// ===== design/scpi_pool_ram.sv =====
// pool entry memory, one write and one read port, registered read
module scpi_pool_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output scpi_pkg::entry_t  rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  scpi_pkg::entry_t  wr_data
);

	scpi_pkg::entry_t mem_q [DEPTH];
	scpi_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/scpi_ctrl.sv =====
// sequencer: clear sweep, insert search and shift, entry read and flag clear
module scpi_ctrl #(
	parameter int CAP = 64,
	parameter int AW  = 6,
	parameter int LW  = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	scpi_req_if.sink          req,
	input  logic [LW-1:0]     len,
	output logic              res_valid,
	output scpi_pkg::res_t    res,
	input  logic              res_take,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  scpi_pkg::entry_t  rd_data,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output scpi_pkg::entry_t  wr_data
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_FIRST, S_LAST, S_BS, S_SCAN, S_HI, S_SHIFT, S_RDE, S_PUT
	} state_t;

	localparam logic [AW-1:0] LAST_ADDR = AW'(CAP - 1);

	state_t           state_q;
	logic [1:0]       func_q;
	logic [31:0]      id_q;
	logic [31:0]      key_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    lo_q;
	logic [AW-1:0]    hi_q;
	logic [AW-1:0]    mid_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    sh_rd_q;
	logic [AW-1:0]    sh_prev_q;
	logic             sh_pend_q;
	logic             sh_more_q;
	logic [AW-1:0]    clr_cnt_q;
	logic             clr_reply_q;
	scpi_pkg::res_t   res_q;

	logic             accept;
	logic             idx_ok;
	logic [AW-1:0]    hi_init;
	logic             key_gt;
	logic             key_lt;
	logic             id_eq;
	logic [AW-1:0]    b_lo;
	logic [AW-1:0]    b_hi;
	logic             b_narrow;
	logic [AW:0]      b_sum;
	logic [AW-1:0]    b_mid;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign idx_ok    = 32'(req.entry_index) < 32'(CAP);
	assign hi_init   = AW'(len - LW'(1));
	assign key_gt    = rd_data.distance > key_q;
	assign key_lt    = rd_data.distance < key_q;
	assign id_eq     = rd_data.id == id_q;
	assign res_valid = (state_q == S_PUT);
	assign res       = res_q;

	// bounds of the search range after this cycle's compare
	always_comb begin
		b_lo = lo_q;
		b_hi = hi_q;
		if (state_q == S_LAST) begin
			b_lo = '0;
		end else if (state_q == S_BS) begin
			b_lo = key_gt ? lo_q : mid_q;
			b_hi = key_gt ? mid_q : hi_q;
		end
	end

	assign b_narrow = ({1'b0, b_lo} + (AW+1)'(1)) < {1'b0, b_hi};
	assign b_sum    = {1'b0, b_lo} + {1'b0, b_hi};
	assign b_mid    = AW'(b_sum >> 1);

	// memory requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = scpi_pkg::ENTRY_RESET;
		unique case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
			end
			S_IDLE: begin
				if (accept && req.func == scpi_pkg::FN_INSERT) begin
					rd_en = 1'b1;
				end else if (accept && req.func != scpi_pkg::FN_CLEAR && idx_ok) begin
					rd_en   = 1'b1;
					rd_addr = AW'(req.entry_index);
				end
			end
			S_FIRST: begin
				rd_en   = !key_gt;
				rd_addr = hi_q;
			end
			S_LAST, S_BS: begin
				rd_en   = (state_q == S_BS) || !key_lt;
				rd_addr = b_narrow ? b_mid : b_lo;
			end
			S_SCAN: begin
				rd_en   = !id_eq;
				rd_addr = (lo_q != '0 && !key_lt) ? lo_q - AW'(1) : hi_q;
			end
			S_SHIFT: begin
				rd_en   = sh_more_q;
				rd_addr = sh_rd_q;
				if (sh_pend_q) begin
					wr_en   = 1'b1;
					wr_addr = sh_prev_q + AW'(1);
					wr_data = rd_data;
				end else if (!sh_more_q) begin
					wr_en   = 1'b1;
					wr_addr = pos_q;
					wr_data = '{id: id_q, distance: key_q, flag: 1'b1};
				end
			end
			S_RDE: begin
				if (func_q == scpi_pkg::FN_FLAG_CLR) begin
					wr_en   = 1'b1;
					wr_addr = idx_q;
					wr_data = '{id: rd_data.id, distance: rd_data.distance, flag: 1'b0};
				end
			end
			S_HI, S_PUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			func_q      <= '0;
			id_q        <= '0;
			key_q       <= '0;
			idx_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			pos_q       <= '0;
			sh_rd_q     <= '0;
			sh_prev_q   <= '0;
			sh_pend_q   <= 1'b0;
			sh_more_q   <= 1'b0;
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == LAST_ADDR) begin
						res_q       <= '{status: scpi_pkg::ST_DONE, default: '0};
						state_q     <= clr_reply_q ? S_PUT : S_IDLE;
						clr_reply_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						func_q <= req.func;
						id_q   <= req.new_id;
						key_q  <= req.new_distance;
						idx_q  <= AW'(req.entry_index);
						hi_q   <= hi_init;
						res_q  <= '{status: scpi_pkg::ST_DONE, default: '0};
						case (req.func)
							scpi_pkg::FN_CLEAR: begin
								clr_cnt_q   <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= S_CLR;
							end
							scpi_pkg::FN_INSERT: begin
								state_q <= S_FIRST;
							end
							default: begin
								state_q <= idx_ok ? S_RDE : S_PUT;
							end
						endcase
					end
				end
				S_FIRST: begin
					if (key_gt) begin
						pos_q     <= '0;
						sh_more_q <= hi_init != '0;
						sh_rd_q   <= hi_init - AW'(1);
						sh_pend_q <= 1'b0;
						state_q   <= S_SHIFT;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST, S_BS: begin
					if (state_q == S_LAST && key_lt) begin
						res_q   <= '{status: scpi_pkg::ST_BEYOND, default: '0};
						state_q <= S_PUT;
					end else begin
						lo_q <= b_lo;
						hi_q <= b_hi;
						if (b_narrow) begin
							mid_q   <= b_mid;
							state_q <= S_BS;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (id_eq) begin
						res_q   <= '{status: scpi_pkg::ST_DUPLICATE, default: '0};
						state_q <= S_PUT;
					end else if (lo_q != '0 && !key_lt) begin
						lo_q <= lo_q - AW'(1);
					end else begin
						state_q <= S_HI;
					end
				end
				S_HI: begin
					if (id_eq) begin
						res_q   <= '{status: scpi_pkg::ST_DUPLICATE, default: '0};
						state_q <= S_PUT;
					end else begin
						pos_q     <= hi_q;
						sh_more_q <= hi_q < hi_init;
						sh_rd_q   <= hi_init - AW'(1);
						sh_pend_q <= 1'b0;
						state_q   <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					sh_pend_q <= sh_more_q;
					sh_prev_q <= sh_rd_q;
					if (sh_more_q) begin
						if (sh_rd_q == pos_q) begin
							sh_more_q <= 1'b0;
						end else begin
							sh_rd_q <= sh_rd_q - AW'(1);
						end
					end else if (!sh_pend_q) begin
						res_q   <= '{status: scpi_pkg::ST_INSERTED,
							position: scpi_pkg::POS_W'(pos_q), default: '0};
						state_q <= S_PUT;
					end
				end
				S_RDE: begin
					res_q <= '{status: scpi_pkg::ST_DONE, position: '0,
						entry_id: rd_data.id, entry_distance: rd_data.distance,
						entry_flag: rd_data.flag && func_q != scpi_pkg::FN_FLAG_CLR};
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/sorted_candidate_pool_insert.sv =====
// top level of the sorted candidate pool: config register, sequencer, memory, result register
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+-------------------------------------------------
//  req     | in  | valid/ready   | func, new_id, new_distance, entry_index
//  rsp     | out | valid/ready   | status, position, entry_id, entry_distance, entry_flag
//  cfg     | in  | cfg_wr_en     | cfg_wr_data = pool_size
//
//  one word at a time; an insert reads the first and the last entry, then bisects the range
//  (b steps, about log2 of the active length), checks the entries of the equal-key run and
//  moves the entries behind the insert point, one read at a time through the single read port
//  of the pool memory; a head insert shifts every entry up, a tail reject ends after the last
//  entry is read; after reset a clearing pass over all POOL_CAPACITY entries runs before req.ready rises
//  a result waits in the output register; the sequencer holds only while it is still full
module sorted_candidate_pool_insert #(
	parameter int POOL_CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	scpi_req_if.sink                      req,
	scpi_rsp_if.source                    rsp,
	input  logic                          cfg_wr_en,
	input  logic [scpi_pkg::CFG_W-1:0]    cfg_wr_data
);

	localparam int AW = $clog2(POOL_CAPACITY);
	localparam int LW = $clog2(POOL_CAPACITY + 1);
	localparam int CW = (LW > scpi_pkg::CFG_W) ? LW : scpi_pkg::CFG_W;

	logic [scpi_pkg::CFG_W-1:0] pool_size_q;
	logic [CW-1:0]              ps_w;
	logic [CW-1:0]              cap_w;
	logic [CW-1:0]              len_w;
	logic [LW-1:0]              len;

	logic                       res_valid;
	scpi_pkg::res_t             res;
	logic                       res_take;
	logic                       rsp_valid_q;
	scpi_pkg::res_t             rsp_q;

	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	scpi_pkg::entry_t           rd_data;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	scpi_pkg::entry_t           wr_data;

	// pool size register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= scpi_pkg::POOL_SIZE_RESET;
		end else if (cfg_wr_en) begin
			pool_size_q <= cfg_wr_data;
		end
	end

	// active length, saturated to one .. capacity
	assign ps_w  = CW'(pool_size_q);
	assign cap_w = CW'(POOL_CAPACITY);
	assign len_w = (ps_w == '0) ? CW'(1) : ((ps_w > cap_w) ? cap_w : ps_w);
	assign len   = LW'(len_w);

	scpi_ctrl #(
		.CAP (POOL_CAPACITY),
		.AW  (AW),
		.LW  (LW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.len       (len),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	scpi_pool_ram #(
		.DEPTH (POOL_CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// output register: loads whenever empty or being drained
	assign res_take = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_q.status;
	assign rsp.position       = rsp_q.position;
	assign rsp.entry_id       = rsp_q.entry_id;
	assign rsp.entry_distance = rsp_q.entry_distance;
	assign rsp.entry_flag     = rsp_q.entry_flag;

	// a finished result never coincides with taking a new word
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req.ready)
		else $error("result pending while request accepted");

	// active length always within one .. capacity
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len != '0) && (len <= LW'(POOL_CAPACITY)))
		else $error("active length out of range");

	// position only reported for a placed candidate
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != scpi_pkg::ST_INSERTED) |-> (rsp.position == '0))
		else $error("position set without insert");

	// entry fields only carried by read and flag clear
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != scpi_pkg::ST_DONE) |->
		(rsp.entry_id == '0 && rsp.entry_distance == '0 && !rsp.entry_flag))
		else $error("entry fields set on insert result");

endmodule
